// ===== rtl/core/nfd_pkg.sv =====
package nfd_pkg;

   localparam int DIGIT_WORDS = 8;
   localparam int IDX_W       = $clog2(DIGIT_WORDS);
   localparam int DIGIT_W     = 14;
   localparam int LEN_W       = 5;
   localparam int COUNT_W     = 7;
   localparam int VALUE_W     = 64;
   localparam int HALF_W      = 32;
   localparam int CARRY_W     = 15;
   localparam int MAC_W       = HALF_W + CARRY_W;
   localparam int FRAC_W      = 8;

   localparam int SIGN_BIT        = 5;
   localparam int WEIGHT_SIGN_BIT = 6;

   localparam logic [DIGIT_W-1:0] BASE_WHOLE = 14'd10000;
   localparam logic [DIGIT_W-1:0] BASE_FRAC  = 14'd100;
   // d / 100 == (d * 5243) >> 19 for every 14-bit d
   localparam logic [DIGIT_W-1:0] RECIP_100  = 14'd5243;
   localparam int                 RECIP_SHIFT = 19;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_QUOT,
      ST_LO,
      ST_HI,
      ST_DONE
   } nfd_state_type;

endpackage

// ===== rtl/core/nfd_mac.sv =====
module nfd_mac (
   input  logic [nfd_pkg::HALF_W-1:0]  mul_a,
   input  logic [nfd_pkg::DIGIT_W-1:0] mul_b,
   input  logic [nfd_pkg::CARRY_W-1:0] add_c,
   output logic [nfd_pkg::MAC_W-1:0]   result
);
   import nfd_pkg::*;

   // 32 x 14 multiply plus a 15-bit addend never exceeds 47 bits
   assign result = MAC_W'(mul_a) * MAC_W'(mul_b) + MAC_W'(add_c);

endmodule

// ===== rtl/core/numeric_to_fixed_decimal_core.sv =====
// Converts one short-header packed decimal field to a signed value times 100.
// A request is taken when start is high and busy is low; busy then stays high
// until the result strobe. All arithmetic runs through one shared 32 x 14
// multiply-add unit, which takes two passes (low and high word) per digit,
// plus one pass up front for the fractional digit divided by 100. With weight
// w >= 0 the field uses w + 2 digit words, with a negative weight one word.
// busy covers the quotient pass, the passes for each word and a done state,
// the result is registered after the done state, and the next request can be
// taken in the same cycle that the result is shown. rsp_valid is high for
// exactly one cycle per request and the receiver cannot stall it. Overflow
// wraps modulo 2^64 without a flag.
module numeric_to_fixed_decimal_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [7:0]                   req_header_low,
   input  logic [7:0]                   req_header_high,
   input  logic [nfd_pkg::LEN_W-1:0]    req_field_length,
   input  logic [nfd_pkg::DIGIT_W-1:0]  req_digit_0,
   input  logic [nfd_pkg::DIGIT_W-1:0]  req_digit_1,
   input  logic [nfd_pkg::DIGIT_W-1:0]  req_digit_2,
   input  logic [nfd_pkg::DIGIT_W-1:0]  req_digit_3,
   input  logic [nfd_pkg::DIGIT_W-1:0]  req_digit_4,
   input  logic [nfd_pkg::DIGIT_W-1:0]  req_digit_5,
   input  logic [nfd_pkg::DIGIT_W-1:0]  req_digit_6,
   input  logic [nfd_pkg::DIGIT_W-1:0]  req_digit_7,
   output logic                         rsp_valid,
   output logic signed [nfd_pkg::VALUE_W-1:0] rsp_scaled_value
);
   import nfd_pkg::*;

   nfd_state_type state_ff, state_in;

   logic [DIGIT_W-1:0] digit_ff [DIGIT_WORDS];
   logic [DIGIT_W-1:0] digit_in [DIGIT_WORDS];
   logic [LEN_W-1:0]   flen_ff, flen_in;
   logic               neg_ff, neg_in;
   logic [COUNT_W-1:0] last_ff, last_in;
   logic [COUNT_W-1:0] k_ff, k_in;
   logic [FRAC_W-1:0]  frac_ff, frac_in;
   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic [HALF_W-1:0]  lo_ff, lo_in;
   logic [CARRY_W-1:0] carry_ff, carry_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;

   logic [COUNT_W-1:0] sel_idx;
   logic [DIGIT_W-1:0] sel_digit;
   logic [HALF_W-1:0]  mac_a;
   logic [DIGIT_W-1:0] mac_b;
   logic [CARRY_W-1:0] mac_c;
   logic [MAC_W-1:0]   mac_result;
   logic               accept;
   logic               at_last;
   logic [6:0]         weight;

   assign accept  = start && (state_ff == ST_IDLE);
   assign at_last = (k_ff == last_ff);
   assign weight  = req_header_low[6:0];

   nfd_mac u_mac (
      .mul_a  (mac_a),
      .mul_b  (mac_b),
      .add_c  (mac_c),
      .result (mac_result)
   );

   // digit word k exists only below the word count and inside the field
   always_comb begin
      sel_idx   = (state_ff == ST_QUOT) ? last_ff : k_ff;
      sel_digit = '0;
      if ((sel_idx < COUNT_W'(DIGIT_WORDS)) &&
          (({1'b0, sel_idx} << 1) + 8'd2 < {3'b000, flen_ff})) begin
         sel_digit = digit_ff[sel_idx[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff     <= digit_in;
      flen_ff      <= flen_in;
      neg_ff       <= neg_in;
      last_ff      <= last_in;
      k_ff         <= k_in;
      frac_ff      <= frac_in;
      acc_ff       <= acc_in;
      lo_ff        <= lo_in;
      carry_ff     <= carry_in;
      rsp_value_ff <= rsp_value_in;
   end

   always_comb begin
      state_in     = state_ff;
      digit_in     = digit_ff;
      flen_in      = flen_ff;
      neg_in       = neg_ff;
      last_in      = last_ff;
      k_in         = k_ff;
      frac_in      = frac_ff;
      acc_in       = acc_ff;
      lo_in        = lo_ff;
      carry_in     = carry_ff;
      rsp_valid_in = 1'b0;
      rsp_value_in = rsp_value_ff;
      mac_a        = '0;
      mac_b        = '0;
      mac_c        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               digit_in[0] = req_digit_0;
               digit_in[1] = req_digit_1;
               digit_in[2] = req_digit_2;
               digit_in[3] = req_digit_3;
               digit_in[4] = req_digit_4;
               digit_in[5] = req_digit_5;
               digit_in[6] = req_digit_6;
               digit_in[7] = req_digit_7;
               flen_in     = req_field_length;
               neg_in      = req_header_high[SIGN_BIT];
               // negative weight: only the fractional digit
               last_in     = weight[WEIGHT_SIGN_BIT] ? '0 : weight + 7'd1;
               k_in        = '0;
               acc_in      = '0;
               state_in    = ST_QUOT;
            end
         end
         ST_QUOT: begin
            mac_a    = HALF_W'(sel_digit);
            mac_b    = RECIP_100;
            frac_in  = mac_result[RECIP_SHIFT +: FRAC_W];
            state_in = ST_LO;
         end
         ST_LO: begin
            mac_a    = acc_ff[HALF_W-1:0];
            mac_b    = at_last ? BASE_FRAC : BASE_WHOLE;
            mac_c    = at_last ? CARRY_W'(frac_ff) : CARRY_W'(sel_digit);
            lo_in    = mac_result[HALF_W-1:0];
            carry_in = mac_result[MAC_W-1:HALF_W];
            state_in = ST_HI;
         end
         ST_HI: begin
            mac_a  = acc_ff[VALUE_W-1:HALF_W];
            mac_b  = at_last ? BASE_FRAC : BASE_WHOLE;
            mac_c  = carry_ff;
            acc_in = {mac_result[HALF_W-1:0], lo_ff};
            if (at_last) begin
               state_in = ST_DONE;
            end else begin
               k_in     = k_ff + 7'd1;
               state_in = ST_LO;
            end
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = neg_ff ? ('0 - acc_ff) : acc_ff;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_scaled_value = rsp_value_ff;

   a_one_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held longer than one cycle");

   a_lo_then_hi: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LO) |=> (state_ff == ST_HI))
      else $error("low pass not followed by high pass");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_LO) || (state_ff == ST_HI)) |-> (k_ff <= last_ff))
      else $error("digit counter ran past the last digit");

endmodule
